// ----- src/keypad_four_function_calculator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the keypad calculator checks
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_ASSERT_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_ASSERT_SVH

// same-cycle implication
`define KCALC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kcalc: same-cycle check failed");

// next-cycle implication
`define KCALC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kcalc: next-cycle check failed");

`endif

// ----- src/kcalc_pkg.sv -----
// ----------------------------------------------------------------------------
// kcalc_pkg
// Shared widths, key codes and limits for the keypad calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kcalc_pkg;

  // operand width (16..64); results are sign-extended to 64 bits
  localparam int VW = 64;
  // serial engine width: room for magnitude * 10 + 9
  localparam int EW = VW + 4;
  // iteration counter width, holds VW
  localparam int CW = $clog2(VW + 1);

  // key classes
  localparam logic [2:0] KEY_DIGIT  = 3'd0;
  localparam logic [2:0] KEY_OPER   = 3'd1;
  localparam logic [2:0] KEY_EQUALS = 3'd2;
  localparam logic [2:0] KEY_BACK   = 3'd3;
  localparam logic [2:0] KEY_CLEAR  = 3'd4;

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [3:0] TEN       = 4'd10;

  // pending operator
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  // saturation limits
  localparam logic [VW-1:0] MAX_VAL = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] MIN_VAL = {1'b1, {(VW-1){1'b0}}};
  localparam logic [EW-1:0] POS_LIM = {{(EW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic [EW-1:0] NEG_LIM = {{(EW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};

endpackage

// ----- src/keypad_four_function_calculator.sv -----
// ----------------------------------------------------------------------------
// keypad_four_function_calculator
// Path, accept to m_tvalid: add, subtract, clear and divide by zero go straight
// to the output register; a digit runs 4 shift-add steps, then the post step;
// multiply, divide and backspace run the one-bit-per-cycle shift-add /
// restoring-divide engine, then the post step. Keys without a result leave the
// block ready. One key in flight; the next key is taken from the cycle after its
// result beat loads. Reset (rst, synchronous): operands zero, no operator
// pending, no beat out.
`timescale 1ns / 1ps

module keypad_four_function_calculator (
  input  logic        clk,
  input  logic        rst,
  // key beat
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] digit, [5:4] operation, [7:6] zero
  input  logic [2:0]  s_tuser,   // [2:0] kind
  // result beat
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] shown_value
  output logic [0:0]  m_tuser    // [0] undefined
);

  localparam int VW = kcalc_pkg::VW;
  localparam int EW = kcalc_pkg::EW;
  localparam int CW = kcalc_pkg::CW;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;  // shift-add, one multiplier bit per cycle
  localparam logic [2:0] S_DIV  = 3'd2;  // restoring divide, one quotient bit per cycle
  localparam logic [2:0] S_POST = 3'd3;  // sign fix, saturation, operand write
  localparam logic [2:0] S_FIN  = 3'd4;  // wait for the output register

  // what the post step does with the engine result
  localparam logic [1:0] JOB_MUL   = 2'd0;
  localparam logic [1:0] JOB_DIV   = 2'd1;
  localparam logic [1:0] JOB_BACK  = 2'd2;
  localparam logic [1:0] JOB_DIGIT = 2'd3;

  function automatic logic [VW-1:0] mag(input logic [VW-1:0] x);
    return x[VW-1] ? (VW'(0) - x) : x;
  endfunction

  // architectural state
  logic [VW-1:0] first_op;
  logic [VW-1:0] second_op;
  logic [2:0]    pend_op;
  logic [2:0]    state;

  // serial engine: acc is accumulator / partial remainder, mcand is the
  // multiplicand / divisor, shreg shifts multiplier bits out or quotient bits in
  logic [EW-1:0] acc;
  logic [EW-1:0] mcand;
  logic [VW-1:0] shreg;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          to_second;
  logic [1:0]    job;
  logic [VW-1:0] res_val;
  logic          res_undef;

  logic          key_acc;
  logic [2:0]    kind;
  logic [3:0]    digit;
  logic [1:0]    operation;
  logic [VW-1:0] entry;
  logic [VW-1:0] sum;
  logic [VW-1:0] dif;
  logic [VW:0]   rsh;
  logic [VW:0]   dtrial;
  logic [VW-1:0] post_val;
  logic          out_load;

  assign s_tready  = (state == S_IDLE);
  assign key_acc   = s_tvalid & s_tready;
  assign kind      = s_tuser;
  assign digit     = s_tdata[3:0];
  assign operation = s_tdata[5:4];

  assign entry = (pend_op == kcalc_pkg::OP_NONE) ? first_op : second_op;
  assign sum   = first_op + second_op;
  assign dif   = first_op - second_op;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign rsh    = {acc[VW-1:0], shreg[VW-1]};
  assign dtrial = rsh - {1'b0, mcand[VW-1:0]};

  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  always_comb begin
    post_val = acc[VW-1:0];
    case (job)
      JOB_MUL: begin
        post_val = acc[VW-1:0];
      end
      JOB_DIV, JOB_BACK: begin
        // min / -1 wraps back to min here
        post_val = neg ? (VW'(0) - shreg) : shreg;
      end
      JOB_DIGIT: begin
        if (!neg) begin
          post_val = (acc > kcalc_pkg::POS_LIM) ? kcalc_pkg::MAX_VAL : acc[VW-1:0];
        end else begin
          post_val = (acc > kcalc_pkg::NEG_LIM) ? kcalc_pkg::MIN_VAL
                                                : (VW'(0) - acc[VW-1:0]);
        end
      end
      default: begin
        post_val = acc[VW-1:0];
      end
    endcase
  end

  // control and operands
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      first_op  <= '0;
      second_op <= '0;
      pend_op   <= kcalc_pkg::OP_NONE;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (key_acc) begin
            case (kind)
              kcalc_pkg::KEY_DIGIT: begin
                if (digit <= kcalc_pkg::DIGIT_MAX) begin
                  state <= S_MUL;
                end
              end
              kcalc_pkg::KEY_OPER: begin
                pend_op <= {1'b0, operation} + 3'd1;
              end
              kcalc_pkg::KEY_EQUALS: begin
                case (pend_op)
                  kcalc_pkg::OP_ADD: begin
                    first_op  <= sum;
                    second_op <= '0;
                    state     <= S_FIN;
                  end
                  kcalc_pkg::OP_SUB: begin
                    first_op  <= dif;
                    second_op <= '0;
                    state     <= S_FIN;
                  end
                  kcalc_pkg::OP_MUL: begin
                    state <= S_MUL;
                  end
                  kcalc_pkg::OP_DIV: begin
                    // divide by zero leaves the operands alone
                    state <= (second_op == '0) ? S_FIN : S_DIV;
                  end
                  default: begin
                    state <= S_IDLE;
                  end
                endcase
              end
              kcalc_pkg::KEY_BACK: begin
                state <= S_DIV;
              end
              kcalc_pkg::KEY_CLEAR: begin
                first_op  <= '0;
                second_op <= '0;
                pend_op   <= kcalc_pkg::OP_NONE;
                state     <= S_FIN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MUL, S_DIV: begin
          if (cnt == CW'(1)) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (job == JOB_MUL || job == JOB_DIV) begin
            first_op  <= post_val;
            second_op <= '0;
          end else if (to_second) begin
            second_op <= post_val;
          end else begin
            first_op <= post_val;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // serial datapath and result holding
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        to_second <= (pend_op != kcalc_pkg::OP_NONE);
        case (kind)
          kcalc_pkg::KEY_DIGIT: begin
            // |entry| * 10 + digit in four shift-add steps
            acc   <= EW'(digit);
            mcand <= EW'(mag(entry));
            shreg <= VW'(kcalc_pkg::TEN);
            cnt   <= CW'(4);
            neg   <= entry[VW-1];
            job   <= JOB_DIGIT;
          end
          kcalc_pkg::KEY_BACK: begin
            acc   <= '0;
            mcand <= EW'(kcalc_pkg::TEN);
            shreg <= mag(entry);
            cnt   <= CW'(VW);
            neg   <= entry[VW-1];
            job   <= JOB_BACK;
          end
          default: begin
            // equals, and don't-care for the other keys
            acc <= '0;
            cnt <= CW'(VW);
            if (pend_op == kcalc_pkg::OP_DIV) begin
              mcand <= EW'(mag(second_op));
              shreg <= mag(first_op);
              neg   <= first_op[VW-1] ^ second_op[VW-1];
              job   <= JOB_DIV;
            end else begin
              mcand <= EW'(first_op);
              shreg <= second_op;
              neg   <= 1'b0;
              job   <= JOB_MUL;
            end
          end
        endcase
        if (kind == kcalc_pkg::KEY_EQUALS && pend_op == kcalc_pkg::OP_ADD) begin
          res_val   <= sum;
          res_undef <= 1'b0;
        end else if (kind == kcalc_pkg::KEY_EQUALS && pend_op == kcalc_pkg::OP_SUB) begin
          res_val   <= dif;
          res_undef <= 1'b0;
        end else begin
          res_val <= '0;
          res_undef <= (kind == kcalc_pkg::KEY_EQUALS) &&
                       (pend_op == kcalc_pkg::OP_DIV) && (second_op == '0);
        end
      end
      S_MUL: begin
        if (shreg[0]) begin
          acc <= acc + mcand;
        end
        mcand <= {mcand[EW-2:0], 1'b0};
        shreg <= {1'b0, shreg[VW-1:1]};
        cnt   <= cnt - CW'(1);
      end
      S_DIV: begin
        if (!dtrial[VW]) begin
          acc <= EW'(dtrial[VW-1:0]);
        end else begin
          acc <= EW'(rsh[VW-1:0]);
        end
        shreg <= {shreg[VW-2:0], ~dtrial[VW]};
        cnt   <= cnt - CW'(1);
      end
      S_POST: begin
        res_val   <= post_val;
        res_undef <= 1'b0;
      end
      default: begin
        res_val <= res_val;
      end
    endcase

    if (out_load) begin
      m_tdata <= 64'($signed(res_val));
      m_tuser <= res_undef;
    end
  end

endmodule

// ----- src/kcalc_checker.sv -----
// ----------------------------------------------------------------------------
// kcalc_checker
// Port-level checks on the keypad calculator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keypad_four_function_calculator_assert.svh"

module kcalc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser
);

  logic key_acc;
  assign key_acc = s_tvalid && s_tready;

  // a stalled result beat holds
  `KCALC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // undefined always shows zero
  `KCALC_ASSERT_NOW(a_undef_zero, m_tvalid && m_tuser[0], m_tdata == 64'd0)

  // a valid digit starts the engine, so no key is taken next cycle
  `KCALC_ASSERT_NEXT(a_digit_busy, key_acc && s_tuser == kcalc_pkg::KEY_DIGIT && s_tdata[3:0] <= kcalc_pkg::DIGIT_MAX, !s_tready)

  // an operator key only latches the operator and stays ready
  `KCALC_ASSERT_NEXT(a_oper_ready, key_acc && s_tuser == kcalc_pkg::KEY_OPER, s_tready)

endmodule

bind keypad_four_function_calculator kcalc_checker u_kcalc_checker (.*);
